@@ rtl/core/mcbc_pkg.sv @@
// mcbc_pkg: shared types, codes and character constants of the mail content
// byte classifier. No dependencies; every other file of the block uses it.
package mcbc_pkg;

  localparam int LINE_COUNTER_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF        = 32;

  localparam int FLAG_W    = 11;
  localparam int RPT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int LIMIT_W   = 16;

  // flag_set bit positions
  localparam int FL_LONG   = 0;
  localparam int FL_CRLF   = 1;
  localparam int FL_NUL    = 2;
  localparam int FL_CTRL   = 3;
  localparam int FL_HIGH   = 4;
  localparam int FL_NOTEXT = 5;
  localparam int FL_FROM   = 6;
  localparam int FL_FROM1  = 7;
  localparam int FL_NOTERM = 8;
  localparam int FL_UTF8   = 9;
  localparam int FL_OTHER  = 10;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // previous-byte code for "no byte yet"
  localparam logic [8:0] NO_BYTE     = 9'h100;
  localparam logic [8:0] PREV_CR     = {1'b0, CH_CR};
  localparam logic [8:0] PREV_LF     = {1'b0, CH_LF};
  localparam int         FROM_LEN    = 5;

  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST = 16'd998;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LIMIT   = 3'd0,
    REG_TEXT_CTRL_OK = 3'd1,
    REG_TYPE_UNSET   = 3'd2,
    REG_TYPE_TEXT    = 3'd3,
    REG_DEEP_INSPECT = 3'd4,
    REG_DETECT_UTF8  = 3'd5
  } cfg_reg_t;

  // second-byte range restriction after a UTF-8 lead byte
  localparam logic [2:0] U8R_ANY  = 3'd0;
  localparam logic [2:0] U8R_A0UP = 3'd1;
  localparam logic [2:0] U8R_9FDN = 3'd2;
  localparam logic [2:0] U8R_90UP = 3'd3;
  localparam logic [2:0] U8R_8FDN = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flag_set;
    logic              verdict_final;
    logic [RPT_W-1:0]  total_count;
    logic [RPT_W-1:0]  bogus_count;
    logic [RPT_W-1:0]  highbit_count;
  } result_t;

  // characters of "From "
  function automatic logic [7:0] from_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h46;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h6F;
      3'd3:    ch = 8'h6D;
      3'd4:    ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/mcbc_if.sv @@
// Valid/ready channel interfaces of the mail content byte classifier.
// Depends on mcbc_pkg for field widths.
interface mcbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface mcbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mcbc_pkg::FLAG_W-1:0]  flag_set;
  logic                         verdict_final;
  logic [mcbc_pkg::RPT_W-1:0]   total_count;
  logic [mcbc_pkg::RPT_W-1:0]   bogus_count;
  logic [mcbc_pkg::RPT_W-1:0]   highbit_count;

  modport source (output valid, flag_set, verdict_final, total_count, bogus_count,
                  highbit_count, input ready);
  modport sink   (input valid, flag_set, verdict_final, total_count, bogus_count,
                  highbit_count, output ready);
endinterface

@@ rtl/core/mcbc_utf8.sv @@
// mcbc_utf8: UTF-8 byte decode, continuation check and lead-byte length/range.
// Depends on mcbc_pkg.
module mcbc_utf8 (
  input  logic [7:0] c,
  input  logic [2:0] range_sel,
  output logic       cont_ok,
  output logic       lead_ok,
  output logic [1:0] lead_pend,
  output logic [2:0] lead_range
);

  always_comb begin
    cont_ok = 1'b0;
    if (c inside {[8'h80:8'hBF]}) begin
      case (range_sel)
        mcbc_pkg::U8R_A0UP: cont_ok = (c >= 8'hA0);
        mcbc_pkg::U8R_9FDN: cont_ok = (c <= 8'h9F);
        mcbc_pkg::U8R_90UP: cont_ok = (c >= 8'h90);
        mcbc_pkg::U8R_8FDN: cont_ok = (c <= 8'h8F);
        default:            cont_ok = 1'b1;
      endcase
    end
  end

  always_comb begin
    lead_pend  = 2'd0;
    lead_range = mcbc_pkg::U8R_ANY;
    if (c inside {[8'hC2:8'hDF]}) begin
      lead_pend = 2'd1;
    end else if (c == 8'hE0) begin
      lead_pend  = 2'd2;
      lead_range = mcbc_pkg::U8R_A0UP;
    end else if (c == 8'hED) begin
      lead_pend  = 2'd2;
      lead_range = mcbc_pkg::U8R_9FDN;
    end else if (c inside {[8'hE1:8'hEF]}) begin
      lead_pend = 2'd2;
    end else if (c == 8'hF0) begin
      lead_pend  = 2'd3;
      lead_range = mcbc_pkg::U8R_90UP;
    end else if (c == 8'hF4) begin
      lead_pend  = 2'd3;
      lead_range = mcbc_pkg::U8R_8FDN;
    end else if (c inside {[8'hF1:8'hF3]}) begin
      lead_pend = 2'd3;
    end
    lead_ok = (lead_pend != 2'd0);
  end

endmodule

@@ rtl/core/mcbc_class.sv @@
// mcbc_class: configuration registers, classifier state and the one-byte
// state update. Depends on mcbc_pkg and instantiates mcbc_utf8.
module mcbc_class #(
  parameter int LINE_COUNTER_BITS = mcbc_pkg::LINE_COUNTER_BITS_DEF,
  parameter int COUNT_BITS        = mcbc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mcbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcbc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            step_en,
  input  mcbc_pkg::item_t                 item,
  output mcbc_pkg::result_t               res_nxt
);

  localparam int LW = LINE_COUNTER_BITS;
  localparam int CB = COUNT_BITS;
  localparam int CMP_W = (LW > mcbc_pkg::LIMIT_W) ? LW : mcbc_pkg::LIMIT_W;

  logic [mcbc_pkg::LIMIT_W-1:0] limit_r;
  logic tco_r, unset_r, text_r, deep_r;

  logic [LW-1:0]  ll_r, ll_nxt;
  logic [8:0]     prev_r, prev_nxt;
  logic [mcbc_pkg::FLAG_W-1:0] fl_r, fl_nxt;
  logic           first_r, first_nxt;
  logic [2:0]     pm_r, pm_nxt;
  logic           pok_r, pok_nxt;
  logic [1:0]     upend_r, upend_nxt;
  logic [2:0]     urng_r, urng_nxt;
  logic           dact_r, dact_nxt;
  logic           frz_r, frz_nxt;
  logic [CB-1:0]  bt_r, bt_nxt, bo_r, bo_nxt, hb_r, hb_nxt;

  logic       cont_ok, lead_ok;
  logic [1:0] lead_pend;
  logic [2:0] lead_range;

  mcbc_utf8 u_utf8 (
    .c          (item.data_byte),
    .range_sel  (urng_r),
    .cont_ok    (cont_ok),
    .lead_ok    (lead_ok),
    .lead_pend  (lead_pend),
    .lead_range (lead_range)
  );

  always_comb begin
    logic [7:0] c;
    logic [8:0] lastc;
    logic       printable;
    logic       long_hit;
    logic       body_done;

    c         = item.data_byte;
    lastc     = prev_r;
    printable = (c >= mcbc_pkg::CH_SP) && (c < mcbc_pkg::CH_DEL);
    long_hit  = (CMP_W'(ll_r) >= CMP_W'(limit_r));
    body_done = 1'b0;

    ll_nxt    = ll_r;
    prev_nxt  = prev_r;
    fl_nxt    = fl_r;
    first_nxt = first_r;
    pm_nxt    = pm_r;
    pok_nxt   = pok_r;
    upend_nxt = upend_r;
    urng_nxt  = urng_r;
    dact_nxt  = dact_r;
    frz_nxt   = frz_r;
    bt_nxt    = bt_r;
    bo_nxt    = bo_r;
    hb_nxt    = hb_r;

    if (step_en && !frz_r) begin
      if (item.end_of_data) begin
        if (dact_r && (upend_r != 2'd0)) begin
          dact_nxt  = 1'b0;
          upend_nxt = 2'd0;
          urng_nxt  = mcbc_pkg::U8R_ANY;
          fl_nxt[mcbc_pkg::FL_UTF8]  = 1'b0;
          fl_nxt[mcbc_pkg::FL_OTHER] = 1'b1;
        end
        prev_nxt  = mcbc_pkg::NO_BYTE;
        first_nxt = 1'b0;
        if (long_hit) fl_nxt[mcbc_pkg::FL_LONG] = 1'b1;
        if (lastc == mcbc_pkg::PREV_CR) fl_nxt[mcbc_pkg::FL_CRLF] = 1'b1;
        if (lastc != mcbc_pkg::PREV_LF) fl_nxt[mcbc_pkg::FL_NOTERM] = 1'b1;
      end else begin
        bt_nxt   = (bt_r == {CB{1'b1}}) ? bt_r : bt_r + CB'(1);
        prev_nxt = {1'b0, c};
        if (dact_r && (upend_r != 2'd0) && !cont_ok) begin
          dact_nxt  = 1'b0;
          upend_nxt = 2'd0;
          urng_nxt  = mcbc_pkg::U8R_ANY;
          fl_nxt[mcbc_pkg::FL_UTF8]  = 1'b0;
          fl_nxt[mcbc_pkg::FL_OTHER] = 1'b1;
        end
        if (c == mcbc_pkg::CH_LF) begin
          first_nxt = 1'b0;
          if (long_hit) fl_nxt[mcbc_pkg::FL_LONG] = 1'b1;
          if (lastc == mcbc_pkg::PREV_CR) fl_nxt[mcbc_pkg::FL_CRLF] = 1'b1;
          ll_nxt  = '0;
          pm_nxt  = 3'd0;
          pok_nxt = 1'b1;
        end else begin
          // "From " matcher over the first five bytes of a line
          if (!fl_r[mcbc_pkg::FL_FROM] && (ll_r < LW'(mcbc_pkg::FROM_LEN))) begin
            if (printable && pok_r && (pm_r == ll_r[2:0]) &&
                (c == mcbc_pkg::from_char(ll_r[2:0]))) begin
              pm_nxt = ll_r[2:0] + 3'd1;
              if (ll_r[2:0] == 3'(mcbc_pkg::FROM_LEN - 1)) begin
                fl_nxt[mcbc_pkg::FL_FROM] = 1'b1;
                if (first_r) fl_nxt[mcbc_pkg::FL_FROM1] = 1'b1;
              end
            end else begin
              pok_nxt = 1'b0;
            end
          end

          if (c == mcbc_pkg::CH_NUL) begin
            fl_nxt[mcbc_pkg::FL_NUL] = 1'b1;
            if (!tco_r) begin
              fl_nxt[mcbc_pkg::FL_NOTEXT] = 1'b1;
              frz_nxt = 1'b1;
            end
            body_done = 1'b1;
          end
          if (!body_done) begin
            // lone CR shows up on the byte after it
            if (lastc == mcbc_pkg::PREV_CR) fl_nxt[mcbc_pkg::FL_CTRL] = 1'b1;
            if ((c < mcbc_pkg::CH_SP) || (c == mcbc_pkg::CH_DEL)) begin
              if ((c != mcbc_pkg::CH_TAB) && (c != mcbc_pkg::CH_CR))
                fl_nxt[mcbc_pkg::FL_CTRL] = 1'b1;
              if (!(c inside {[mcbc_pkg::CH_BEL:mcbc_pkg::CH_CR], mcbc_pkg::CH_ESC})) begin
                bo_nxt = (bo_r == {CB{1'b1}}) ? bo_r : bo_r + CB'(1);
                if (!deep_r) begin
                  fl_nxt[mcbc_pkg::FL_NUL] = 1'b1;
                  if (!tco_r) begin
                    fl_nxt[mcbc_pkg::FL_NOTEXT] = 1'b1;
                    frz_nxt = 1'b1;
                  end
                end
              end
            end else if (c[7]) begin
              fl_nxt[mcbc_pkg::FL_HIGH] = 1'b1;
              hb_nxt = (hb_r == {CB{1'b1}}) ? hb_r : hb_r + CB'(1);
              if (!(unset_r | text_r)) begin
                fl_nxt[mcbc_pkg::FL_NUL]    = 1'b1;
                fl_nxt[mcbc_pkg::FL_NOTEXT] = 1'b1;
                frz_nxt = 1'b1;
              end else if (dact_nxt) begin
                if (upend_nxt != 2'd0) begin
                  upend_nxt = upend_nxt - 2'd1;
                  urng_nxt  = mcbc_pkg::U8R_ANY;
                  if (upend_nxt == 2'd0) fl_nxt[mcbc_pkg::FL_UTF8] = 1'b1;
                end else if (lead_ok) begin
                  upend_nxt = lead_pend;
                  urng_nxt  = lead_range;
                end else begin
                  dact_nxt  = 1'b0;
                  upend_nxt = 2'd0;
                  urng_nxt  = mcbc_pkg::U8R_ANY;
                  fl_nxt[mcbc_pkg::FL_UTF8]  = 1'b0;
                  fl_nxt[mcbc_pkg::FL_OTHER] = 1'b1;
                end
              end
            end
          end
          if (!frz_nxt) ll_nxt = (ll_r == {LW{1'b1}}) ? ll_r : ll_r + LW'(1);
        end
      end
    end

    // writing detect_utf8 reloads detection and drops a pending sequence
    if (cfg_we && (cfg_index == mcbc_pkg::REG_DETECT_UTF8)) begin
      dact_nxt  = cfg_data[0];
      upend_nxt = 2'd0;
      urng_nxt  = mcbc_pkg::U8R_ANY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mcbc_pkg::LINE_LIMIT_RST;
      tco_r   <= 1'b0;
      unset_r <= 1'b1;
      text_r  <= 1'b0;
      deep_r  <= 1'b0;
      ll_r    <= '0;
      prev_r  <= mcbc_pkg::NO_BYTE;
      fl_r    <= '0;
      first_r <= 1'b1;
      pm_r    <= 3'd0;
      pok_r   <= 1'b1;
      upend_r <= 2'd0;
      urng_r  <= mcbc_pkg::U8R_ANY;
      dact_r  <= 1'b0;
      frz_r   <= 1'b0;
      bt_r    <= '0;
      bo_r    <= '0;
      hb_r    <= '0;
    end else begin
      ll_r    <= ll_nxt;
      prev_r  <= prev_nxt;
      fl_r    <= fl_nxt;
      first_r <= first_nxt;
      pm_r    <= pm_nxt;
      pok_r   <= pok_nxt;
      upend_r <= upend_nxt;
      urng_r  <= urng_nxt;
      dact_r  <= dact_nxt;
      frz_r   <= frz_nxt;
      bt_r    <= bt_nxt;
      bo_r    <= bo_nxt;
      hb_r    <= hb_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mcbc_pkg::REG_LINE_LIMIT:   limit_r <= cfg_data[mcbc_pkg::LIMIT_W-1:0];
          mcbc_pkg::REG_TEXT_CTRL_OK: tco_r   <= cfg_data[0];
          mcbc_pkg::REG_TYPE_UNSET:   unset_r <= cfg_data[0];
          mcbc_pkg::REG_TYPE_TEXT:    text_r  <= cfg_data[0];
          mcbc_pkg::REG_DEEP_INSPECT: deep_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // counters report their low 32 bits
  localparam int RW = mcbc_pkg::RPT_W;
  logic [RW-1:0] bt_rpt, bo_rpt, hb_rpt;
  if (CB >= RW) begin : g_rpt_trunc
    assign bt_rpt = bt_nxt[RW-1:0];
    assign bo_rpt = bo_nxt[RW-1:0];
    assign hb_rpt = hb_nxt[RW-1:0];
  end else begin : g_rpt_ext
    assign bt_rpt = {{(RW-CB){1'b0}}, bt_nxt};
    assign bo_rpt = {{(RW-CB){1'b0}}, bo_nxt};
    assign hb_rpt = {{(RW-CB){1'b0}}, hb_nxt};
  end

  assign res_nxt.flag_set      = fl_nxt;
  assign res_nxt.verdict_final = frz_nxt;
  assign res_nxt.total_count   = bt_rpt;
  assign res_nxt.bogus_count   = bo_rpt;
  assign res_nxt.highbit_count = hb_rpt;

  a_frozen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    frz_r |=> frz_r)
    else $error("mcbc_class: freeze released without reset");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    frz_r |-> (fl_nxt == fl_r && bt_nxt == bt_r && ll_nxt == ll_r))
    else $error("mcbc_class: state moved while frozen");

  a_notext_is_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    fl_r[mcbc_pkg::FL_NOTEXT] == frz_r || !frz_r)
    else $error("mcbc_class: frozen without not-text flag");

  a_pend_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (upend_r != 2'd0) |-> dact_r)
    else $error("mcbc_class: UTF-8 sequence pending with detection off");

endmodule

@@ rtl/core/mail_content_byte_classifier.sv @@
// mail_content_byte_classifier: top level; input register, classifier and
// result register. Depends on mcbc_pkg, mcbc_if and mcbc_class.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid/ready   | data_byte[7:0], end_of_data
//   out_ch  | out | valid/ready   | flag_set[10:0], verdict_final, 3 x 32-bit counts
//   cfg_*   | in  | write enable  | cfg_index[2:0], cfg_data[15:0]
//
// One transaction per cycle sustained while out_ch is not stalled; a result passes
// through the input register, then the result register, to out_ch.
// The rate is set by the classifier state update loop.
// Synchronous active-low reset clears state and counters and loads default configuration.
// A stalled result holds; in_ch.ready drops only when both registers are full.
module mail_content_byte_classifier #(
  parameter int LINE_COUNTER_BITS = mcbc_pkg::LINE_COUNTER_BITS_DEF,
  parameter int COUNT_BITS        = mcbc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mcbc_in_if.sink                        in_ch,
  mcbc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [mcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcbc_pkg::CFG_W-1:0]     cfg_data
);

  logic              stg_v_r;
  mcbc_pkg::item_t   stg_r;
  logic              out_v_r;
  mcbc_pkg::result_t out_r;
  mcbc_pkg::result_t res_nxt;
  logic              advance;

  assign advance     = stg_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stg_v_r || advance;

  mcbc_class #(
    .LINE_COUNTER_BITS (LINE_COUNTER_BITS),
    .COUNT_BITS        (COUNT_BITS)
  ) u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (advance),
    .item      (stg_r),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) stg_v_r <= in_ch.valid;
      if (advance) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_r.data_byte   <= in_ch.data_byte;
      stg_r.end_of_data <= in_ch.end_of_data;
    end
    if (advance) out_r <= res_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.flag_set      = out_r.flag_set;
  assign out_ch.verdict_final = out_r.verdict_final;
  assign out_ch.total_count   = out_r.total_count;
  assign out_ch.bogus_count   = out_r.bogus_count;
  assign out_ch.highbit_count = out_r.highbit_count;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (stg_v_r && out_v_r && !out_ch.ready))
    else $error("top: input stalled with room in the pipeline");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("top: result lost after stage advance");

  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.verdict_final && advance) |=> out_r.verdict_final)
    else $error("top: verdict cleared without reset");

  a_notext_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.flag_set[mcbc_pkg::FL_NOTEXT] == out_r.verdict_final))
    else $error("top: not-text flag and verdict disagree");

endmodule

@@ tb/mail_content_byte_classifier_tb.sv @@
// Self-checking testbench for mail_content_byte_classifier: a directed table, then phases of
// random mail bodies under different register settings, checked against an in-bench predictor.
// Depends on mcbc_pkg and the mcbc_in_if / mcbc_out_if channel interfaces.
module mail_content_byte_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcbc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [39:0] FROM_WORD = "From ";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
    logic       typed;       // want holds a hand-written expectation
    result_t    want;
  } stim_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MASK, RX_EVERY4} rx_mode_t;

  // Hand-checked rows are the "From " line, the high-byte extremes and the double end mark.
  localparam stim_t DIRECTED [21] = '{
    '{8'h46, 1'b0, 1'b1, '{11'h000, 1'b0, 32'd1, 32'd0, 32'd0}},
    '{8'h72, 1'b0, 1'b0, '0},
    '{8'h6F, 1'b0, 1'b0, '0},
    '{8'h6D, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b1, '{11'h0C0, 1'b0, 32'd5, 32'd0, 32'd0}},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{11'h0D0, 1'b0, 32'd7, 32'd0, 32'd2}},
    '{8'h0D, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h0D, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    '{8'h07, 1'b0, 1'b0, '0},
    '{8'h1B, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0},
    '{8'h0D, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{11'h1DA, 1'b0, 32'd17, 32'd0, 32'd2}},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mcbc_in_if  in_ch ();
  mcbc_out_if out_ch ();

  mail_content_byte_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror
  logic [LIMIT_W-1:0] m_limit = LINE_LIMIT_RST;
  logic m_ctl_ok = 1'b0, m_unset = 1'b1, m_text = 1'b0, m_deep = 1'b0, m_utf8 = 1'b0;

  // classifier state mirror
  logic [15:0] ln_len = '0;
  logic [8:0]  prev_c = NO_BYTE;
  logic [FLAG_W-1:0] flags = '0;
  logic        first_line = 1'b1;
  logic [2:0]  from_pos = '0;
  logic        from_ok = 1'b1;
  logic [1:0]  u8_pend = '0;
  logic [2:0]  u8_rng = U8R_ANY;
  logic        u8_on = 1'b0;
  logic        frozen_m = 1'b0;
  logic [31:0] n_total = '0, n_bogus = '0, n_high = '0;

  result_t expected_reports [$];
  stim_t   body_q [$];
  stim_t   offered;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task u8_abort;
    u8_on = 1'b0;
    u8_pend = '0;
    u8_rng = U8R_ANY;
    flags[FL_UTF8] = 1'b0;
    flags[FL_OTHER] = 1'b1;
  endtask

  task close_line(input logic [8:0] lastc);
    first_line = 1'b0;
    if (ln_len >= m_limit) flags[FL_LONG] = 1'b1;
    if (lastc == PREV_CR) flags[FL_CRLF] = 1'b1;
  endtask

  task classify_byte(input logic [7:0] c, input logic eod, output result_t r);
    logic [8:0] lastc;
    logic cont_good;
    if (!frozen_m) begin
      lastc = prev_c;
      if (eod) begin
        if (u8_on && u8_pend != 0) u8_abort;
        prev_c = NO_BYTE;
        close_line(lastc);
        if (lastc != PREV_LF) flags[FL_NOTERM] = 1'b1;
      end else begin
        if (n_total != '1) n_total++;
        prev_c = {1'b0, c};
        if (u8_on && u8_pend != 0) begin
          cont_good = (c >= 8'h80 && c <= 8'hBF);
          case (u8_rng)
            U8R_A0UP: cont_good = cont_good && c >= 8'hA0;
            U8R_9FDN: cont_good = cont_good && c <= 8'h9F;
            U8R_90UP: cont_good = cont_good && c >= 8'h90;
            U8R_8FDN: cont_good = cont_good && c <= 8'h8F;
            default:  ;
          endcase
          if (!cont_good) u8_abort;
        end
        if (c == CH_LF) begin
          close_line(lastc);
          ln_len = '0;
          from_pos = '0;
          from_ok = 1'b1;
        end else begin
          if (!flags[FL_FROM] && ln_len < FROM_LEN) begin
            if (c >= CH_SP && c < CH_DEL && from_ok && from_pos == ln_len[2:0] &&
                c == FROM_WORD[39 - 8*int'(ln_len) -: 8]) begin
              from_pos = from_pos + 3'd1;
              if (ln_len == FROM_LEN - 1) begin
                flags[FL_FROM] = 1'b1;
                if (first_line) flags[FL_FROM1] = 1'b1;
              end
            end else begin
              from_ok = 1'b0;
            end
          end
          if (c == CH_NUL) begin
            flags[FL_NUL] = 1'b1;
            if (!m_ctl_ok) begin
              flags[FL_NOTEXT] = 1'b1;
              frozen_m = 1'b1;
            end
          end else begin
            if (lastc == PREV_CR) flags[FL_CTRL] = 1'b1;
            if (c < CH_SP || c == CH_DEL) begin
              if (c != CH_TAB && c != CH_CR) flags[FL_CTRL] = 1'b1;
              // BEL..CR and ESC are harmless escapes
              if (!((c >= CH_BEL && c <= CH_CR) || c == CH_ESC)) begin
                if (n_bogus != '1) n_bogus++;
                if (!m_deep) begin
                  flags[FL_NUL] = 1'b1;
                  if (!m_ctl_ok) begin
                    flags[FL_NOTEXT] = 1'b1;
                    frozen_m = 1'b1;
                  end
                end
              end
            end else if (c[7]) begin
              flags[FL_HIGH] = 1'b1;
              if (n_high != '1) n_high++;
              if (!(m_unset || m_text)) begin
                flags[FL_NUL] = 1'b1;
                flags[FL_NOTEXT] = 1'b1;
                frozen_m = 1'b1;
              end else if (u8_on) begin
                if (u8_pend != 0) begin
                  u8_pend--;
                  u8_rng = U8R_ANY;
                  if (u8_pend == 0) flags[FL_UTF8] = 1'b1;
                end else begin
                  u8_rng = U8R_ANY;
                  if (c >= 8'hC2 && c <= 8'hDF) u8_pend = 2'd1;
                  else if (c == 8'hE0) begin
                    u8_pend = 2'd2;
                    u8_rng = U8R_A0UP;
                  end else if (c == 8'hED) begin
                    u8_pend = 2'd2;
                    u8_rng = U8R_9FDN;
                  end else if (c >= 8'hE1 && c <= 8'hEF) u8_pend = 2'd2;
                  else if (c == 8'hF0) begin
                    u8_pend = 2'd3;
                    u8_rng = U8R_90UP;
                  end else if (c == 8'hF4) begin
                    u8_pend = 2'd3;
                    u8_rng = U8R_8FDN;
                  end else if (c >= 8'hF1 && c <= 8'hF3) u8_pend = 2'd3;
                  else u8_abort;
                end
              end
            end
          end
          if (!frozen_m && ln_len != '1) ln_len++;
        end
      end
    end
    r.flag_set      = flags;
    r.verdict_final = frozen_m;
    r.total_count   = n_total;
    r.bogus_count   = n_bogus;
    r.highbit_count = n_high;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t head;
    logic took_in, gave_out;
    took_in  = rst_n && in_ch.valid && in_ch.ready;
    gave_out = rst_n && out_ch.valid && out_ch.ready;
    if (gave_out) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: result with none expected: actual flags %0h total %0h",
                 $time, out_ch.flag_set, out_ch.total_count);
        mismatches++;
      end else begin
        head = expected_reports.pop_front();
        check_field("flag_set", 32'(head.flag_set), 32'(out_ch.flag_set));
        check_field("verdict_final", 32'(head.verdict_final), 32'(out_ch.verdict_final));
        check_field("total_count", head.total_count, out_ch.total_count);
        check_field("bogus_count", head.bogus_count, out_ch.bogus_count);
        check_field("highbit_count", head.highbit_count, out_ch.highbit_count);
      end
    end
    if (took_in) begin
      classify_byte(offered.data_byte, offered.end_of_data, pred);
      expected_reports.push_back(offered.typed ? offered.want : pred);
    end
    if (!rst_n || took_in || gave_out) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure in randomly chosen and randomly changing modes
  int        stall_left = 0;
  rx_mode_t  stall_mode = RX_OPEN;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0]  stall_step = '0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
      stall_mask = 16'($urandom) | 16'h0001;
    end
    stall_left--;
    stall_step++;
    case (stall_mode)
      RX_OPEN:  out_ch.ready <= 1'b1;
      RX_COIN:  out_ch.ready <= 1'($urandom_range(0, 1));
      RX_MASK:  out_ch.ready <= stall_mask[stall_step];
      default:  out_ch.ready <= (stall_step[1:0] != 2'd0);
    endcase
  end

  task automatic add_byte(input logic [7:0] b);
    stim_t s;
    s = '0;
    s.data_byte = b;
    body_q.push_back(s);
  endtask

  task automatic add_end();
    stim_t s;
    s = '0;
    s.data_byte = 8'($urandom);
    s.end_of_data = 1'b1;
    body_q.push_back(s);
  endtask

  // Mostly well-formed text: words, lines, UTF-8, From lines; the rest is noise.
  task automatic compose_body(input int n);
    int sel, k;
    logic [7:0] lead, lo, hi;
    while (body_q.size() < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(8'h21, 8'h7E)));
        add_byte(CH_SP);
      end else if (sel < 45) begin
        k = $urandom_range(1, 3);
        lo = 8'h80;
        hi = 8'hBF;
        case (k)
          1:       lead = 8'($urandom_range(8'hC2, 8'hDF));
          2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
          default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        if (lead == 8'hE0) lo = 8'hA0;
        else if (lead == 8'hED) hi = 8'h9F;
        else if (lead == 8'hF0) lo = 8'h90;
        else if (lead == 8'hF4) hi = 8'h8F;
        add_byte(lead);
        add_byte(8'($urandom_range(lo, hi)));
        repeat (k - 1) add_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (sel < 52) begin
        case ($urandom_range(0, 5))
          0: add_byte(8'($urandom_range(8'h80, 8'hC1)));
          1: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
          2: begin
            add_byte(8'hE0);
            add_byte(8'($urandom_range(8'h80, 8'h9F)));
          end
          3: begin
            add_byte(8'hED);
            add_byte(8'($urandom_range(8'hA0, 8'hBF)));
          end
          4: begin
            add_byte(8'($urandom_range(8'hC2, 8'hF4)));
            add_byte(8'($urandom_range(8'h0A, 8'h7E)));
          end
          default: begin
            add_byte(8'($urandom_range(8'hE1, 8'hEC)));
            add_byte(8'h9A);
            add_end();
          end
        endcase
      end else if (sel < 62) begin
        add_byte(CH_LF);
      end else if (sel < 67) begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end else if (sel < 72) begin
        add_byte(CH_LF);
        k = $urandom_range(0, 7);  // k >= 5 keeps the word intact
        for (int p = 0; p < FROM_LEN; p++)
          add_byte(p == k ? 8'($urandom_range(8'h21, 8'h7E)) : FROM_WORD[39 - 8*p -: 8]);
      end else if (sel < 76) begin
        add_byte(CH_CR);
        add_byte(8'($urandom_range(8'h01, 8'hFF)));
      end else if (sel < 83) begin
        add_byte($urandom_range(0, 1) ? CH_DEL : 8'($urandom_range(8'h01, 8'h1F)));
      end else if (sel < 86) begin
        add_byte(CH_NUL);
      end else if (sel < 90) begin
        add_end();
      end else begin
        add_byte(8'($urandom));
      end
    end
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_all();
    stim_t s;
    while (body_q.size() != 0) begin
      s = body_q.pop_front();
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= s.data_byte;
      in_ch.end_of_data <= s.end_of_data;
      offered = s;
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
      burst_left--;
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_LINE_LIMIT:   m_limit  = v;
      REG_TEXT_CTRL_OK: m_ctl_ok = v[0];
      REG_TYPE_UNSET:   m_unset  = v[0];
      REG_TYPE_TEXT:    m_text   = v[0];
      REG_DEEP_INSPECT: m_deep   = v[0];
      REG_DETECT_UTF8: begin
        m_utf8  = v[0];
        u8_on   = v[0];
        u8_pend = '0;
        u8_rng  = U8R_ANY;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Upper data bits of the one-bit registers are junk on purpose.
  task automatic apply_setup(input logic [15:0] limit, input logic ctl_ok, input logic unset,
                             input logic text, input logic deep, input logic utf8);
    drain();
    put_reg(REG_LINE_LIMIT, limit);
    put_reg(REG_TEXT_CTRL_OK, {15'($urandom), ctl_ok});
    put_reg(REG_TYPE_UNSET, {15'($urandom), unset});
    put_reg(REG_TYPE_TEXT, {15'($urandom), text});
    put_reg(REG_DEEP_INSPECT, {15'($urandom), deep});
    put_reg(REG_DETECT_UTF8, {15'($urandom), utf8});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_data = 1'b0;
    out_ch.ready = 1'b0;
    offered = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed rows run under the reset settings, nothing here may freeze the block
    foreach (DIRECTED[i]) body_q.push_back(DIRECTED[i]);
    send_all();

    apply_setup(16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    compose_body(150);
    send_all();
    apply_setup(16'd40, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
    compose_body(150);
    send_all();
    apply_setup(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    compose_body(120);
    send_all();
    apply_setup(16'd12, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
    compose_body(140);
    send_all();
    // strict binary settings: the verdict freezes the block for the rest of the run
    apply_setup(16'd80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    compose_body(50);
    send_all();

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
